// File: rtl/bsfd_pkg.sv
package bsfd_pkg;

    localparam int BYTE_W = 8;

    // configuration register indexes
    localparam logic [1:0] CFG_FRAME_DELIMITER        = 2'd0;
    localparam logic [1:0] CFG_ESCAPE_CODE            = 2'd1;
    localparam logic [1:0] CFG_ESCAPED_DELIMITER_CODE = 2'd2;
    localparam logic [1:0] CFG_ESCAPED_ESCAPE_CODE    = 2'd3;

    localparam logic [BYTE_W-1:0] RST_FRAME_DELIMITER        = 8'd192;
    localparam logic [BYTE_W-1:0] RST_ESCAPE_CODE            = 8'd219;
    localparam logic [BYTE_W-1:0] RST_ESCAPED_DELIMITER_CODE = 8'd220;
    localparam logic [BYTE_W-1:0] RST_ESCAPED_ESCAPE_CODE    = 8'd221;

    // one decoded output byte
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } result_t;

    // results produced by one input byte, in order (r0 first)
    typedef struct packed {
        logic [1:0] cnt;
        result_t    r0;
        result_t    r1;
    } result_pair_t;

endpackage

// File: rtl/byte_stuffed_frame_deframer.sv
// Results of a taken request are registered in the queue, then offered on out_valid.
// Throughput: one input byte per cycle, held off while the result queue lacks room for
// two results; output drains one byte per cycle while out_ready is high.
// Reset (rst_n, async, active low): escape and hold flags cleared, queue emptied,
// registers back to 192 / 219 / 220 / 221.
module byte_stuffed_frame_deframer
    import bsfd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4  // power of two, at least 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    // configuration write port
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [BYTE_W-1:0] cfg_data,
    // stuffed byte stream in
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BYTE_W-1:0] in_byte,
    // decoded frame bytes out
    output logic              out_valid,
    input  logic              out_ready,
    output logic [BYTE_W-1:0] out_byte,
    output logic              frame_last
);

    result_pair_t res;
    logic         take;
    logic         room;

    // in_ready depends only on queue fill, never on in_valid
    assign in_ready = room;
    assign take     = in_valid && in_ready;

    // Unstuffing decoder: escape flag, one held-back byte so the frame's
    // final byte can be marked last when the delimiter arrives.
    bsfd_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .take      (take),
        .in_byte   (in_byte),
        .res       (res)
    );

    // Result queue: takes up to two results per request, presents one per cycle while out_ready is high.
    bsfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (res),
        .room       (room),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .frame_last (frame_last)
    );

endmodule

// File: rtl/bsfd_core.sv
module bsfd_core
    import bsfd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [BYTE_W-1:0] cfg_data,
    input  logic              take,
    input  logic [BYTE_W-1:0] in_byte,
    output result_pair_t      res
);

    logic [BYTE_W-1:0] frame_delimiter_reg;
    logic [BYTE_W-1:0] escape_code_reg;
    logic [BYTE_W-1:0] escaped_delimiter_code_reg;
    logic [BYTE_W-1:0] escaped_escape_code_reg;

    logic              escape_pending_reg;
    logic              escape_pending_next;
    logic              holding_valid_reg;
    logic              holding_valid_next;
    logic [BYTE_W-1:0] held_byte_reg;
    logic [BYTE_W-1:0] held_byte_next;

    // decoded bytes appended to the frame by this input
    logic [1:0]        push_cnt;
    logic [BYTE_W-1:0] push0;
    logic [BYTE_W-1:0] push1;
    logic              close_frame;

    always_comb
    begin
        push_cnt            = 2'd0;
        push0               = in_byte;
        push1               = in_byte;
        close_frame         = 1'b0;
        escape_pending_next = escape_pending_reg;
        if (escape_pending_reg)
        begin
            escape_pending_next = 1'b0;
            if (in_byte == escaped_delimiter_code_reg)
            begin
                push_cnt = 2'd1;
                push0    = frame_delimiter_reg;
            end
            else if (in_byte == escaped_escape_code_reg)
            begin
                push_cnt = 2'd1;
                push0    = escape_code_reg;
            end
            else
            begin
                push_cnt = 2'd2;
                push0    = escape_code_reg;
                push1    = in_byte;
            end
        end
        else if (in_byte == escape_code_reg)
        begin
            escape_pending_next = 1'b1;
        end
        else if (in_byte == frame_delimiter_reg)
        begin
            close_frame = 1'b1;
        end
        else
        begin
            push_cnt = 2'd1;
            push0    = in_byte;
        end
    end

    // held byte goes out first; the newest pushed byte is held back
    always_comb
    begin
        res                = '0;
        holding_valid_next = holding_valid_reg;
        held_byte_next     = held_byte_reg;
        if (close_frame)
        begin
            if (holding_valid_reg)
            begin
                res.cnt     = 2'd1;
                res.r0.data = held_byte_reg;
                res.r0.last = 1'b1;
            end
            holding_valid_next = 1'b0;
        end
        else if (push_cnt == 2'd1)
        begin
            if (holding_valid_reg)
            begin
                res.cnt     = 2'd1;
                res.r0.data = held_byte_reg;
            end
            holding_valid_next = 1'b1;
            held_byte_next     = push0;
        end
        else if (push_cnt == 2'd2)
        begin
            if (holding_valid_reg)
            begin
                res.cnt     = 2'd2;
                res.r0.data = held_byte_reg;
                res.r1.data = push0;
            end
            else
            begin
                res.cnt     = 2'd1;
                res.r0.data = push0;
            end
            holding_valid_next = 1'b1;
            held_byte_next     = push1;
        end
        if (!take)
        begin
            res.cnt = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_delimiter_reg        <= RST_FRAME_DELIMITER;
            escape_code_reg            <= RST_ESCAPE_CODE;
            escaped_delimiter_code_reg <= RST_ESCAPED_DELIMITER_CODE;
            escaped_escape_code_reg    <= RST_ESCAPED_ESCAPE_CODE;
            escape_pending_reg         <= 1'b0;
            holding_valid_reg          <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FRAME_DELIMITER:        frame_delimiter_reg        <= cfg_data;
                    CFG_ESCAPE_CODE:            escape_code_reg            <= cfg_data;
                    CFG_ESCAPED_DELIMITER_CODE: escaped_delimiter_code_reg <= cfg_data;
                    CFG_ESCAPED_ESCAPE_CODE:    escaped_escape_code_reg    <= cfg_data;
                    default: ;
                endcase
            end
            if (take)
            begin
                escape_pending_reg <= escape_pending_next;
                holding_valid_reg  <= holding_valid_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            held_byte_reg <= held_byte_next;
        end
    end

endmodule

// File: rtl/bsfd_queue.sv
module bsfd_queue
    import bsfd_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  result_pair_t      wr,
    output logic              room,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [BYTE_W-1:0] out_byte,
    output logic              frame_last
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    result_t          mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [PTR_W-1:0] wr_ptr_plus1;
    logic             pop;

    assign pop          = out_valid && out_ready;
    assign out_valid    = (count_reg != '0);
    assign out_byte     = mem_reg[rd_ptr_reg].data;
    assign frame_last   = mem_reg[rd_ptr_reg].last;
    // two free slots needed since one byte can expand to two results
    assign room         = (count_reg <= CNT_W'(DEPTH - 2));
    assign wr_ptr_plus1 = wr_ptr_reg + PTR_W'(1);
    assign count_next   = count_reg + CNT_W'(wr.cnt) - CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(wr.cnt);
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.cnt != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= wr.r0;
        end
        if (wr.cnt == 2'd2)
        begin
            mem_reg[wr_ptr_plus1] <= wr.r1;
        end
    end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import bsfd_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS  = 170;   // least number of stuffed bytes per configuration phase
    localparam int NUM_PHASES   = 6;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [1:0]        cfg_index = '0;
    logic [BYTE_W-1:0] cfg_data = '0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [BYTE_W-1:0] in_byte = '0;
    logic              out_valid;
    logic              out_ready = 1'b1;
    logic [BYTE_W-1:0] out_byte;
    logic              frame_last;

    byte_stuffed_frame_deframer dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .frame_last (frame_last)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Shadow of the deframer: register copies and unstuffing state
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0] delim_cfg     = RST_FRAME_DELIMITER;
    logic [BYTE_W-1:0] esc_cfg       = RST_ESCAPE_CODE;
    logic [BYTE_W-1:0] esc_delim_cfg = RST_ESCAPED_DELIMITER_CODE;
    logic [BYTE_W-1:0] esc_esc_cfg   = RST_ESCAPED_ESCAPE_CODE;

    logic              esc_armed  = 1'b0;
    logic              hold_valid = 1'b0;
    logic [BYTE_W-1:0] hold_byte  = '0;

    result_t           decoded_q[$];   // decoded bytes still due from the block
    logic [BYTE_W-1:0] stuffed_q[$];   // stuffed bytes waiting to be requested

    int err_cnt   = 0;
    int cycle_cnt = 0;
    int sender_max_gap = 0;
    int recv_max_stall = 0;

    task automatic report(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        err_cnt++;
    endtask

    // One byte is always held back so the frame's final byte can carry last.
    function automatic void append_decoded(input logic [BYTE_W-1:0] b);
        result_t r;
        if (hold_valid) begin
            r.data = hold_byte;
            r.last = 1'b0;
            decoded_q.push_back(r);
        end
        hold_byte  = b;
        hold_valid = 1'b1;
    endfunction

    function automatic void unstuff_byte(input logic [BYTE_W-1:0] b);
        result_t r;
        if (esc_armed) begin
            // escape partner: delimiter code wins over escape code when equal;
            // an unknown partner (a delimiter included) passes as escape + raw
            esc_armed = 1'b0;
            if (b == esc_delim_cfg) begin
                append_decoded(delim_cfg);
            end
            else if (b == esc_esc_cfg) begin
                append_decoded(esc_cfg);
            end
            else begin
                append_decoded(esc_cfg);
                append_decoded(b);
            end
        end
        else if (b == esc_cfg) begin
            esc_armed = 1'b1;
        end
        else if (b == delim_cfg) begin
            // empty frame gives nothing
            if (hold_valid) begin
                r.data = hold_byte;
                r.last = 1'b1;
                decoded_q.push_back(r);
                hold_valid = 1'b0;
            end
        end
        else begin
            append_decoded(b);
        end
    endfunction

    // ------------------------------------------------------------------
    // Driver: presents stuffed bytes with a random gap after each request
    // ------------------------------------------------------------------
    int gap_left = 0;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_byte  <= '0;
            gap_left <= 0;
        end
        else if (!in_valid || in_ready) begin
            if (gap_left != 0) begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (stuffed_q.size() != 0) begin
                in_valid <= 1'b1;
                in_byte  <= stuffed_q.pop_front();
                gap_left <= $urandom_range(0, sender_max_gap);
            end
            else begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stall after each decoded byte taken
    // ------------------------------------------------------------------
    int stall_left = 0;

    always @(posedge clk or negedge rst_n) begin
        int stall;
        if (!rst_n) begin
            out_ready  <= 1'b1;
            stall_left <= 0;
        end
        else if (out_valid && out_ready) begin
            stall = $urandom_range(0, recv_max_stall);
            if (stall != 0) begin
                out_ready  <= 1'b0;
                stall_left <= stall;
            end
        end
        else if (!out_ready) begin
            if (stall_left <= 1)
                out_ready <= 1'b1;
            stall_left <= stall_left - 1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predicts on each input request, then checks each output.
    // Both sides are looked at in one block so the prediction is always
    // queued before the matching output is compared.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        result_t want;
        if (rst_n) begin
            if (in_valid && in_ready)
                unstuff_byte(in_byte);
            if (out_valid && out_ready) begin
                if (decoded_q.size() == 0) begin
                    report($sformatf("unexpected byte %02h last %0b", out_byte, frame_last));
                end
                else begin
                    want = decoded_q.pop_front();
                    if (out_byte !== want.data)
                        report($sformatf("out_byte got %02h want %02h", out_byte, want.data));
                    if (frame_last !== want.last)
                        report($sformatf("frame_last got %0b want %0b (byte %02h)",
                                         frame_last, want.last, want.data));
                end
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // wait for an empty pipe, plus DRAIN_CYCLES for an escape still in flight
    task automatic wait_drained();
        @(negedge clk);
        while (stuffed_q.size() != 0 || in_valid || decoded_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [BYTE_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_FRAME_DELIMITER:        delim_cfg     = val;
            CFG_ESCAPE_CODE:            esc_cfg       = val;
            CFG_ESCAPED_DELIMITER_CODE: esc_delim_cfg = val;
            CFG_ESCAPED_ESCAPE_CODE:    esc_esc_cfg   = val;
            default: ;
        endcase
    endtask

    task automatic load_codes(input logic [BYTE_W-1:0] d, input logic [BYTE_W-1:0] e,
                              input logic [BYTE_W-1:0] ed, input logic [BYTE_W-1:0] ee);
        write_reg(CFG_FRAME_DELIMITER, d);
        write_reg(CFG_ESCAPE_CODE, e);
        write_reg(CFG_ESCAPED_DELIMITER_CODE, ed);
        write_reg(CFG_ESCAPED_ESCAPE_CODE, ee);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // bit 0: sender gaps, bit 1: receiver stalls
    task automatic set_idling(input int mode);
        sender_max_gap = mode[0] ? 5 : 0;
        recv_max_stall = mode[1] ? 5 : 0;
    endtask

    // biased toward the four codes so escapes and delimiters are frequent
    function automatic logic [BYTE_W-1:0] pick_byte();
        case ($urandom_range(0, 9))
            0:       return delim_cfg;
            1:       return esc_cfg;
            2:       return esc_delim_cfg;
            3:       return esc_esc_cfg;
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly well-formed stuffed frames with random payload; some broken
    // escapes, missing delimiters and loose noise bytes. Returns bytes queued.
    function automatic int add_frame();
        int len;
        int n;
        logic [BYTE_W-1:0] p;
        n   = 0;
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                stuffed_q.push_back(pick_byte());
                n++;
            end
        end
        repeat (len) begin
            p = pick_byte();
            if ($urandom_range(0, 11) == 0) begin
                // unstuffed raw byte, or an escape with an arbitrary partner
                if ($urandom_range(0, 1)) begin
                    stuffed_q.push_back(esc_cfg);
                    n++;
                end
                stuffed_q.push_back(p);
                n++;
            end
            else if (p == esc_cfg) begin
                stuffed_q.push_back(esc_cfg);
                stuffed_q.push_back(esc_esc_cfg);
                n += 2;
            end
            else if (p == delim_cfg) begin
                stuffed_q.push_back(esc_cfg);
                stuffed_q.push_back(esc_delim_cfg);
                n += 2;
            end
            else begin
                stuffed_q.push_back(p);
                n++;
            end
        end
        if ($urandom_range(0, 11) != 0) begin
            stuffed_q.push_back(delim_cfg);
            n++;
        end
        return n;
    endfunction

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        int queued;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed, reset codes: C0 delimiter, DB escape, DC / DD partners
        set_idling(0);
        stuffed_q.push_back(8'hC0);                       // empty frame
        stuffed_q.push_back(8'h00);
        stuffed_q.push_back(8'hFF);
        stuffed_q.push_back(8'hC0);                       // 00, FF(last)
        stuffed_q.push_back(8'hDB); stuffed_q.push_back(8'hDC);   // -> C0
        stuffed_q.push_back(8'hDB); stuffed_q.push_back(8'hDD);   // -> DB
        stuffed_q.push_back(8'hDB); stuffed_q.push_back(8'h55);   // unknown: DB, 55
        stuffed_q.push_back(8'hDB); stuffed_q.push_back(8'hC0);   // delimiter as partner
        stuffed_q.push_back(8'hDB); stuffed_q.push_back(8'hDB);   // escape as partner
        stuffed_q.push_back(8'hC0);
        stuffed_q.push_back(8'h5A);
        stuffed_q.push_back(8'hC0);                       // one-byte frame
        stuffed_q.push_back(8'hC0);                       // back-to-back delimiter
        stuffed_q.push_back(8'hA5);
        stuffed_q.push_back(8'hDB);                       // escape left pending
        wait_drained();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: load_codes(RST_FRAME_DELIMITER, RST_ESCAPE_CODE,
                              RST_ESCAPED_DELIMITER_CODE, RST_ESCAPED_ESCAPE_CODE);
                1: load_codes(8'h00, 8'hFF, 8'h01, 8'hFE);
                2: load_codes(8'hFF, 8'h00, 8'hFF, 8'h00);   // partners collide with codes
                3: load_codes(8'h7E, 8'h7E, 8'h7E, 8'h7E);   // all codes equal
                4: load_codes(8'h10, 8'h20, 8'h30, 8'h30);   // both partners equal
                default: load_codes(BYTE_W'($urandom_range(0, 255)),
                                    BYTE_W'($urandom_range(0, 255)),
                                    BYTE_W'($urandom_range(0, 255)),
                                    BYTE_W'($urandom_range(0, 255)));
            endcase
            // two halves per phase; the sender stops in between until all
            // decoded bytes have come back
            for (int half = 0; half < 2; half++) begin
                set_idling((2 * ph + half) % 4);
                queued = 0;
                while (queued < PHASE_ITEMS / 2)
                    queued += add_frame();
                wait_drained();
            end
        end

        if (err_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: filelist.f
rtl/bsfd_pkg.sv
rtl/bsfd_core.sv
rtl/bsfd_queue.sv
rtl/byte_stuffed_frame_deframer.sv
bench/testbench.sv
